// ----- hw/rtl/scpp_pkg.sv -----
// shared types, widths and constants of the supercap charge power controller
// no dependencies; used by the register file, the divider, the top level and the testbench
package scpp_pkg;

    // configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // register indexes
    localparam logic [2:0] REG_POWER_TARGET   = 3'd0;
    localparam logic [2:0] REG_PROTECT_BUFFER = 3'd1;
    localparam logic [2:0] REG_DISCHARGE_MIN  = 3'd2;
    localparam logic [2:0] REG_OVERVOLT       = 3'd3;
    localparam logic [2:0] REG_INTEG_LIMIT    = 3'd4;
    localparam logic [2:0] REG_SPEED_SCALE    = 3'd5;

    // register reset values
    localparam logic [13:0] RST_POWER_TARGET   = 14'd4800;
    localparam logic [9:0]  RST_PROTECT_BUFFER = 10'd50;
    localparam logic [15:0] RST_DISCHARGE_MIN  = 16'd12000;
    localparam logic [15:0] RST_OVERVOLT       = 16'd23500;
    localparam logic [11:0] RST_INTEG_LIMIT    = 12'd2000;
    localparam logic [15:0] RST_SPEED_SCALE    = 16'd7900;

    // set-point range and charge command ceiling
    localparam logic [10:0] SP_FLOOR = 11'd1270;
    localparam logic [10:0] SP_CEIL  = 11'd1600;
    localparam logic [12:0] C_MAX    = 13'd1000;

    // shared divider: dividend, divisor, quotient and step counter widths
    localparam int DIV_NW = 44;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 13;
    localparam int DIV_CW = 4;

    // constant divisors
    localparam logic [DIV_DW-1:0] DIV_INTEG = 32'd3200;
    localparam logic [DIV_DW-1:0] DIV_DAC   = 32'd3300;
    localparam logic [DIV_DW-1:0] DIV_RATIO = 32'd38400;

    typedef struct packed {
        logic [13:0] power_target;
        logic [9:0]  protect_buffer_min;
        logic [15:0] discharge_min_mv;
        logic [15:0] overvolt_mv;
        logic [11:0] integrator_limit;
        logic [15:0] speed_scale;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

endpackage

// ----- hw/rtl/scpp_in_if.sv -----
// input channel of the supercap charge power controller: one control tick word
// no dependencies
interface scpp_in_if;
    logic               valid;
    logic               ready;
    logic               starting;
    logic               boost_key;
    logic               steady_motion;
    logic signed [16:0] speed_target;
    logic [13:0]        measured_power;
    logic [9:0]         power_remaining;
    logic [15:0]        cap_millivolts;

    modport source (
        output valid, starting, boost_key, steady_motion, speed_target,
               measured_power, power_remaining, cap_millivolts,
        input  ready
    );
    modport sink (
        input  valid, starting, boost_key, steady_motion, speed_target,
               measured_power, power_remaining, cap_millivolts,
        output ready
    );
endinterface

// ----- hw/rtl/scpp_out_if.sv -----
// output channel of the supercap charge power controller: one result word
// no dependencies
interface scpp_out_if;
    logic        valid;
    logic        ready;
    logic        charge_enable;
    logic        discharge_enable;
    logic [10:0] setpoint_mv;
    logic [11:0] dac_code;

    modport source (
        output valid, charge_enable, discharge_enable, setpoint_mv, dac_code,
        input  ready
    );
    modport sink (
        input  valid, charge_enable, discharge_enable, setpoint_mv, dac_code,
        output ready
    );
endinterface

// ----- hw/rtl/scpp_cfg.sv -----
// apb-style configuration registers of the supercap charge power controller
// depends on scpp_pkg
module scpp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpp_pkg::CFG_AW-1:0]   paddr,
    input  logic [scpp_pkg::CFG_DW-1:0]   pwdata,
    output logic [scpp_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output scpp_pkg::t_cfg                o_cfg
);
    import scpp_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[CFG_AW-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_target       <= RST_POWER_TARGET;
            r_cfg.protect_buffer_min <= RST_PROTECT_BUFFER;
            r_cfg.discharge_min_mv   <= RST_DISCHARGE_MIN;
            r_cfg.overvolt_mv        <= RST_OVERVOLT;
            r_cfg.integrator_limit   <= RST_INTEG_LIMIT;
            r_cfg.speed_scale        <= RST_SPEED_SCALE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POWER_TARGET:   r_cfg.power_target       <= pwdata[13:0];
                REG_PROTECT_BUFFER: r_cfg.protect_buffer_min <= pwdata[9:0];
                REG_DISCHARGE_MIN:  r_cfg.discharge_min_mv   <= pwdata[15:0];
                REG_OVERVOLT:       r_cfg.overvolt_mv        <= pwdata[15:0];
                REG_INTEG_LIMIT:    r_cfg.integrator_limit   <= pwdata[11:0];
                REG_SPEED_SCALE:    r_cfg.speed_scale        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_POWER_TARGET:   prdata = CFG_DW'(r_cfg.power_target);
            REG_PROTECT_BUFFER: prdata = CFG_DW'(r_cfg.protect_buffer_min);
            REG_DISCHARGE_MIN:  prdata = CFG_DW'(r_cfg.discharge_min_mv);
            REG_OVERVOLT:       prdata = CFG_DW'(r_cfg.overvolt_mv);
            REG_INTEG_LIMIT:    prdata = CFG_DW'(r_cfg.integrator_limit);
            REG_SPEED_SCALE:    prdata = CFG_DW'(r_cfg.speed_scale);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/scpp_div.sv -----
// shared restoring divider, one quotient bit per cycle, DIV_QW steps per pass
// depends on scpp_pkg; the quotient must stay below 2**DIV_QW
module scpp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scpp_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [scpp_pkg::DIV_QW-1:0]   o_quot
);
    import scpp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dv;
    logic [DIV_QW-1:0] r_q;

    logic [DIV_NW-1:0] w_shift;
    logic [DIV_NW:0]   w_diff;
    logic              w_ge;

    // trial subtract of the divisor aligned at the current quotient bit
    assign w_shift = {{(DIV_NW-DIV_DW){1'b0}}, r_dv} << r_cnt;
    assign w_diff  = {1'b0, r_rem} - {1'b0, w_shift};
    assign w_ge    = !w_diff[DIV_NW];

    assign o_done = r_done;
    assign o_quot = r_q;

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_QW - 1);
                r_rem  <= i_req.dividend;
                r_dv   <= i_req.divisor;
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem        <= w_diff[DIV_NW-1:0];
                    r_q[r_cnt]   <= 1'b1;
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/supercap_charge_power_pi_unit.sv -----
// supercap charge power controller: gain-scheduled pid on power error
// the shared divider makes up to three 13-step passes per word (integrator, ratio, dac code);
// the ratio pass is skipped when the pid sum is not positive or the ratio numerator is zero,
// and a starting word makes only the dac pass; a new word is taken only once idle again
// a finished word waits in the output register while the next word is accepted
// reset (synchronous, active low): registers to defaults, integrator, error and set-point to 0
module supercap_charge_power_pi_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scpp_in_if.sink                       i_in,
    scpp_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpp_pkg::CFG_AW-1:0]   paddr,
    input  logic [scpp_pkg::CFG_DW-1:0]   pwdata,
    output logic [scpp_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import scpp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INT  = 4'd1;
    localparam logic [3:0] S_INTW = 4'd2;
    localparam logic [3:0] S_PID  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_RATW = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_DAC  = 4'd7;
    localparam logic [3:0] S_DACW = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    t_cfg              w_cfg;
    t_div_req          w_req;
    logic              w_div_done;
    logic [DIV_QW-1:0] w_quot;

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    // latched word
    logic               r_boost;
    logic               r_steady;
    logic signed [16:0] r_speed;
    logic [13:0]        r_power;
    logic [9:0]         r_remain;
    logic [15:0]        r_capmv;

    // pid state
    logic signed [12:0] r_isum;
    logic signed [15:0] r_prev;
    logic [10:0]        r_held;

    // working registers
    logic signed [14:0] r_e;
    logic               r_neg;
    logic               r_pg_hi;
    logic [16:0]        r_num;
    logic [16:0]        r_den;
    logic signed [28:0] r_n;
    logic               r_zero;
    logic [10:0]        r_sp;
    logic               r_chg;
    logic               r_dis;
    logic [11:0]        r_dac;

    // output register
    logic               r_ovalid;
    logic               r_ochg;
    logic               r_odis;
    logic [10:0]        r_osp;
    logic [11:0]        r_odac;

    logic               w_in_acc;
    logic               w_out_load;

    scpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // gain select, power error, integrator dividend and speed ratio
    logic               w_ratio1;
    logic signed [4:0]  w_ig;
    logic signed [14:0] w_e;
    logic signed [25:0] w_x;
    logic [25:0]        w_xabs;
    logic signed [17:0] w_sp1;
    logic [17:0]        w_dabs;
    logic [16:0]        w_num;
    logic [16:0]        w_den;
    logic               w_unity;

    always_comb begin
        w_ratio1 = (r_speed == '0) || r_boost;
        if (w_ratio1) begin
            w_ig = 5'sd8;
        end else if (r_steady) begin
            w_ig = 5'sd9;
        end else begin
            w_ig = 5'sd10;
        end
        w_e    = $signed({1'b0, w_cfg.power_target}) - $signed({1'b0, r_power});
        w_x    = 26'(r_isum) * 26'sd3200 + 26'(w_e) * 26'(w_ig);
        w_xabs = w_x[25] ? 26'(-w_x) : 26'(w_x);
        w_sp1  = 18'(r_speed) + 18'sd1;
        w_dabs = w_sp1[17] ? 18'(-w_sp1) : 18'(w_sp1);
        w_num  = r_steady ? {w_cfg.speed_scale, 1'b0} : {1'b0, w_cfg.speed_scale};
        w_den  = w_dabs[16:0];
        w_unity = w_ratio1 || (w_den == '0) || (w_num >= w_den);
    end

    // integrator clamp and pid sum
    logic signed [13:0] w_acc;
    logic signed [13:0] w_lim;
    logic signed [13:0] w_accc;
    logic signed [28:0] w_n;

    always_comb begin
        w_acc = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        w_lim = $signed({2'b00, w_cfg.integrator_limit});
        if (w_acc > w_lim) begin
            w_accc = w_lim;
        end else if (w_acc < -w_lim) begin
            w_accc = -w_lim;
        end else begin
            w_accc = w_acc;
        end
        w_n = 29'(r_e) * (r_pg_hi ? 29'sd3000 : 29'sd2400) + 29'(w_accc) * 29'sd12800
            + 29'(r_e) - 29'(r_prev);
    end

    // ratio product, divisor and charge command
    logic               w_nz;
    logic [DIV_NW-1:0]  w_prod;
    logic [DIV_DW-1:0]  w_rdv;
    logic [12:0]        w_c;
    logic [10:0]        w_spsum;
    logic [10:0]        w_spc;
    logic               w_protect;

    always_comb begin
        w_nz    = r_n[28] || (r_n == '0) || (r_num == '0);
        w_prod  = DIV_NW'(r_n[26:0]) * DIV_NW'(r_num);
        w_rdv   = DIV_DW'(r_den) * DIV_RATIO;
        if (r_zero) begin
            w_c = '0;
        end else if (w_quot > C_MAX) begin
            w_c = C_MAX;
        end else begin
            w_c = w_quot;
        end
        w_spsum = SP_FLOOR + 11'(w_c[9:1]);
        w_spc   = (w_spsum > SP_CEIL) ? SP_CEIL : w_spsum;
        w_protect = (r_remain < w_cfg.protect_buffer_min) || (r_capmv >= w_cfg.overvolt_mv);
    end

    // divider requests from the sequencer
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_INT: begin
                w_req.start    = 1'b1;
                w_req.dividend = DIV_NW'(w_xabs[24:0]);
                w_req.divisor  = DIV_INTEG;
            end
            S_MUL: begin
                w_req.start    = !w_nz;
                w_req.dividend = w_prod;
                w_req.divisor  = w_rdv;
            end
            S_DAC: begin
                w_req.start    = 1'b1;
                w_req.dividend = DIV_NW'({r_sp, 12'b0});
                w_req.divisor  = DIV_DAC;
            end
            default: ;
        endcase
    end

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    assign o_out.valid            = r_ovalid;
    assign o_out.charge_enable    = r_ochg;
    assign o_out.discharge_enable = r_odis;
    assign o_out.setpoint_mv      = r_osp;
    assign o_out.dac_code         = r_odac;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) begin
                n_state = i_in.starting ? S_DAC : S_INT;
            end
            S_INT:  n_state = S_INTW;
            S_INTW: if (w_div_done) begin
                n_state = S_PID;
            end
            S_PID:  n_state = S_MUL;
            S_MUL:  n_state = w_nz ? S_FIN : S_RATW;
            S_RATW: if (w_div_done) begin
                n_state = S_FIN;
            end
            S_FIN:  n_state = S_DAC;
            S_DAC:  n_state = S_DACW;
            S_DACW: if (w_div_done) begin
                n_state = S_DONE;
            end
            S_DONE: if (w_out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, pid state, held set-point and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_isum   <= '0;
            r_prev   <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PID) begin
                r_isum <= w_accc[12:0];
                r_prev <= 16'(r_e);
            end
            if (r_state == S_FIN) begin
                r_held <= w_protect ? SP_FLOOR : w_spc;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_boost  <= i_in.boost_key;
            r_steady <= i_in.steady_motion;
            r_speed  <= i_in.speed_target;
            r_power  <= i_in.measured_power;
            r_remain <= i_in.power_remaining;
            r_capmv  <= i_in.cap_millivolts;
            // starting word repeats the held set-point with both switches off
            r_sp     <= r_held;
            r_chg    <= 1'b0;
            r_dis    <= 1'b0;
        end
        if (r_state == S_INT) begin
            r_e     <= w_e;
            r_neg   <= w_x[25];
            r_pg_hi <= !w_ratio1;
            r_num   <= w_unity ? 17'd1 : w_num;
            r_den   <= w_unity ? 17'd1 : w_den;
        end
        if (r_state == S_PID) begin
            r_n <= w_n;
        end
        if (r_state == S_MUL) begin
            r_zero <= w_nz;
        end
        if (r_state == S_FIN) begin
            r_sp  <= w_protect ? SP_FLOOR : w_spc;
            r_chg <= !w_protect;
            r_dis <= r_boost && (r_capmv > w_cfg.discharge_min_mv);
        end
        if ((r_state == S_DACW) && w_div_done) begin
            r_dac <= w_quot[11:0];
        end
        if (w_out_load) begin
            r_ochg <= r_chg;
            r_odis <= r_dis;
            r_osp  <= r_sp;
            r_odac <= r_dac;
        end
    end

endmodule

// ----- dv/tb_supercap_charge_power_pi_unit.sv -----
// testbench of the supercap charge power controller: directed and random control ticks,
// each result word checked against an in-bench model of the gain-scheduled pid loop
// depends on scpp_pkg, scpp_in_if, scpp_out_if and supercap_charge_power_pi_unit
module tb_supercap_charge_power_pi_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scpp_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 100;
    localparam int PHASE_TICKS     = 150;
    localparam int PHASES          = 10;
    localparam int PRINT_CAP       = 50;

    // one control tick and one result word
    typedef struct {
        logic               starting;
        logic               boost_key;
        logic               steady_motion;
        logic signed [16:0] speed_target;
        logic [13:0]        measured_power;
        logic [9:0]         power_remaining;
        logic [15:0]        cap_millivolts;
    } t_tick;

    typedef struct {
        logic        charge_enable;
        logic        discharge_enable;
        logic [10:0] setpoint_mv;
        logic [11:0] dac_code;
    } t_ctl_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata, prdata;
    logic pready;

    scpp_in_if  tick_if ();
    scpp_out_if ctl_if ();

    supercap_charge_power_pi_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (ctl_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // controller model state and current register values
    t_cfg        cfg_now = '{RST_POWER_TARGET, RST_PROTECT_BUFFER, RST_DISCHARGE_MIN,
                             RST_OVERVOLT, RST_INTEG_LIMIT, RST_SPEED_SCALE};
    longint      integ_sum = 0;
    longint      prev_err  = 0;
    logic [10:0] held_sp   = '0;

    t_tick     tick_q[$];
    t_ctl_word want_ctl_q[$];
    int        n_queued = 0;
    int        n_taken  = 0;
    int        n_words  = 0;
    int        errors   = 0;
    logic      in_took  = 1'b0;

    int          burst_left = 0;
    int          gap_left   = 0;
    logic        hold_arm   = 1'b0;
    logic        hold_seen  = 1'b0;
    int          hold_left  = 0;
    logic [15:0] rx_pat     = '1;
    logic [3:0]  rx_pos     = '0;
    int          idle_cycles = 0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one control tick of the pid loop: enables, set-point and dac code
    task automatic pi_step(input t_tick tk, output t_ctl_word w);
        longint spd, pgain, igain, rnum, rden, err, acc, lim, nsum, cmd;
        logic [10:0] sp;
        w.charge_enable    = 1'b0;
        w.discharge_enable = 1'b0;
        if (tk.starting) begin
            sp = held_sp;
        end else begin
            if (tk.boost_key && tk.cap_millivolts > cfg_now.discharge_min_mv)
                w.discharge_enable = 1'b1;
            // gain schedule and speed ratio rnum/rden, capped at one
            spd = longint'(tk.speed_target);
            if (spd == 0 || tk.boost_key) begin
                pgain = 12;
                igain = 8;
                rnum  = 1;
                rden  = 1;
            end else begin
                rden  = (spd + 1 < 0) ? -(spd + 1) : spd + 1;
                rnum  = longint'(cfg_now.speed_scale) * (tk.steady_motion ? 2 : 1);
                pgain = 15;
                igain = tk.steady_motion ? 9 : 10;
                if (rden == 0 || rnum >= rden) begin
                    rnum = 1;
                    rden = 1;
                end
            end
            // truncated integrator with symmetric clamp
            err = longint'(cfg_now.power_target) - longint'(tk.measured_power);
            lim = longint'(cfg_now.integrator_limit);
            acc = (integ_sum * longint'(DIV_INTEG) + err * igain) / longint'(DIV_INTEG);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ_sum = acc;
            // p, i and d terms in 1/12800 W
            nsum = 200 * pgain * err + 12800 * acc + (err - prev_err);
            prev_err = err;
            if (nsum <= 0 || rnum == 0) begin
                cmd = 0;
            end else begin
                cmd = (nsum * rnum) / (longint'(DIV_RATIO) * rden);
                if (cmd > longint'(C_MAX)) cmd = longint'(C_MAX);
            end
            if (cmd / 2 + longint'(SP_FLOOR) > longint'(SP_CEIL)) sp = SP_CEIL;
            else sp = 11'(cmd / 2 + longint'(SP_FLOOR));
            // protection keeps the loop running but drops charging
            if (tk.power_remaining < cfg_now.protect_buffer_min ||
                tk.cap_millivolts >= cfg_now.overvolt_mv) begin
                sp = SP_FLOOR;
            end else begin
                w.charge_enable = 1'b1;
            end
            held_sp = sp;
        end
        w.setpoint_mv = sp;
        w.dac_code    = 12'((longint'(sp) * 4096) / longint'(DIV_DAC));
    endtask

    // apb transfer: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write with read-back
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want, got;
        want = '0;
        case (idx)
            REG_POWER_TARGET: begin
                cfg_now.power_target = val[13:0];
                want = 32'(val[13:0]);
            end
            REG_PROTECT_BUFFER: begin
                cfg_now.protect_buffer_min = val[9:0];
                want = 32'(val[9:0]);
            end
            REG_DISCHARGE_MIN: begin
                cfg_now.discharge_min_mv = val[15:0];
                want = 32'(val[15:0]);
            end
            REG_OVERVOLT: begin
                cfg_now.overvolt_mv = val[15:0];
                want = 32'(val[15:0]);
            end
            REG_INTEG_LIMIT: begin
                cfg_now.integrator_limit = val[11:0];
                want = 32'(val[11:0]);
            end
            REG_SPEED_SCALE: begin
                cfg_now.speed_scale = val[15:0];
                want = 32'(val[15:0]);
            end
            default: want = '0;
        endcase
        apb_xfer(1'b1, idx, val, got);
        apb_xfer(1'b0, idx, 32'd0, got);
        if (got !== want)
            flag_mismatch($sformatf("register %0d reads %0d, wrote %0d", idx, got, want));
    endtask

    task automatic load_settings(input t_cfg s);
        cfg_write(REG_POWER_TARGET,   32'(s.power_target));
        cfg_write(REG_PROTECT_BUFFER, 32'(s.protect_buffer_min));
        cfg_write(REG_DISCHARGE_MIN,  32'(s.discharge_min_mv));
        cfg_write(REG_OVERVOLT,       32'(s.overvolt_mv));
        cfg_write(REG_INTEG_LIMIT,    32'(s.integrator_limit));
        cfg_write(REG_SPEED_SCALE,    32'(s.speed_scale));
    endtask

    function automatic t_cfg rand_settings();
        t_cfg s;
        s.power_target       = 14'($urandom_range(0, 16383));
        s.protect_buffer_min = 10'($urandom_range(0, 1023));
        s.discharge_min_mv   = 16'($urandom_range(0, 36300));
        s.overvolt_mv        = 16'($urandom_range(0, 36300));
        s.integrator_limit   = 12'($urandom_range(0, 4095));
        s.speed_scale        = 16'($urandom_range(0, 65535));
        return s;
    endfunction

    task automatic offer(input t_tick tk);
        tick_q.push_back(tk);
        n_queued++;
    endtask

    function automatic t_tick mk_tick(input logic st, input logic bk, input logic sm,
                                      input int spd, input int pw, input int rem, input int cap);
        t_tick tk;
        tk.starting        = st;
        tk.boost_key       = bk;
        tk.steady_motion   = sm;
        tk.speed_target    = spd[16:0];
        tk.measured_power  = pw[13:0];
        tk.power_remaining = rem[9:0];
        tk.cap_millivolts  = cap[15:0];
        return tk;
    endfunction

    // random tick, mostly near the thresholds and the power limit
    function automatic t_tick rand_tick();
        int spd, pw, rem, cap, sc;
        sc = int'(cfg_now.speed_scale);
        case ($urandom_range(0, 7))
            0: spd = 0;
            1: spd = -1;
            2, 3: spd = int'($urandom_range(0, 400)) - 200;
            4, 5: begin
                spd = clamp_int(int'($urandom_range(sc / 2, 3 * sc)), 0, 65535);
                if ($urandom_range(0, 1) == 1) spd = -spd;
            end
            default: spd = int'($urandom_range(0, 131071)) - 65536;
        endcase
        if ($urandom_range(0, 7) == 0) pw = int'($urandom_range(0, 16383));
        else pw = clamp_int(int'(cfg_now.power_target) + int'($urandom_range(0, 4096)) - 2048,
                            0, 16383);
        if ($urandom_range(0, 1) == 1) rem = int'($urandom_range(0, 1023));
        else rem = clamp_int(int'(cfg_now.protect_buffer_min) + int'($urandom_range(0, 8)) - 4,
                             0, 1023);
        case ($urandom_range(0, 2))
            0: cap = int'($urandom_range(0, 36300));
            1: cap = clamp_int(int'(cfg_now.discharge_min_mv) + int'($urandom_range(0, 8)) - 4,
                               0, 36300);
            default: cap = clamp_int(int'(cfg_now.overvolt_mv) + int'($urandom_range(0, 8)) - 4,
                                     0, 36300);
        endcase
        return mk_tick($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                       1'($urandom_range(0, 1)), spd, pw, rem, cap);
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_taken != n_queued || want_ctl_q.size() != 0);
    endtask

    // tick driver: bursts of words with random gaps
    always @(negedge i_clk) begin : tick_drv
        t_tick nxt;
        if (!tick_if.valid || in_took) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                tick_if.valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                nxt = tick_q.pop_front();
                tick_if.starting        <= nxt.starting;
                tick_if.boost_key       <= nxt.boost_key;
                tick_if.steady_motion   <= nxt.steady_motion;
                tick_if.speed_target    <= nxt.speed_target;
                tick_if.measured_power  <= nxt.measured_power;
                tick_if.power_remaining <= nxt.power_remaining;
                tick_if.cap_millivolts  <= nxt.cap_millivolts;
                tick_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: random 16-bit stall pattern, or a long hold-off on request
    always @(negedge i_clk) begin : ctl_rx
        logic [15:0] pick;
        if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            ctl_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            ctl_if.ready <= 1'b0;
        end else begin
            rx_pos <= rx_pos + 4'd1;
            if (rx_pos == 4'd0) begin
                case ($urandom_range(0, 3))
                    0: pick = '1;
                    1: pick = 16'($urandom) | 16'($urandom);
                    2: pick = 16'($urandom);
                    default: pick = 16'($urandom) & 16'($urandom);
                endcase
                rx_pat <= pick;
                ctl_if.ready <= pick[0];
            end else begin
                ctl_if.ready <= rx_pat[rx_pos];
            end
        end
    end

    // monitor: predict on accepted ticks, check accepted result words
    always @(posedge i_clk) begin : ctl_mon
        t_tick     tk;
        t_ctl_word w, want_w;
        in_took <= i_rst_n && tick_if.valid && tick_if.ready;
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            tk.starting        = tick_if.starting;
            tk.boost_key       = tick_if.boost_key;
            tk.steady_motion   = tick_if.steady_motion;
            tk.speed_target    = tick_if.speed_target;
            tk.measured_power  = tick_if.measured_power;
            tk.power_remaining = tick_if.power_remaining;
            tk.cap_millivolts  = tick_if.cap_millivolts;
            pi_step(tk, w);
            want_ctl_q.push_back(w);
            n_taken <= n_taken + 1;
        end
        if (i_rst_n && ctl_if.valid && ctl_if.ready) begin
            if (want_ctl_q.size() == 0) begin
                flag_mismatch("result word with no tick pending");
            end else begin
                want_w = want_ctl_q.pop_front();
                if (ctl_if.charge_enable !== want_w.charge_enable)
                    flag_mismatch($sformatf("word %0d charge_enable %b, want %b", n_words,
                                  ctl_if.charge_enable, want_w.charge_enable));
                if (ctl_if.discharge_enable !== want_w.discharge_enable)
                    flag_mismatch($sformatf("word %0d discharge_enable %b, want %b", n_words,
                                  ctl_if.discharge_enable, want_w.discharge_enable));
                if (ctl_if.setpoint_mv !== want_w.setpoint_mv)
                    flag_mismatch($sformatf("word %0d setpoint_mv %0d, want %0d", n_words,
                                  ctl_if.setpoint_mv, want_w.setpoint_mv));
                if (ctl_if.dac_code !== want_w.dac_code)
                    flag_mismatch($sformatf("word %0d dac_code %0d, want %0d", n_words,
                                  ctl_if.dac_code, want_w.dac_code));
            end
            n_words++;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (ctl_if.valid && ctl_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        t_cfg s;
        int   ph, k;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        tick_if.valid           = 1'b0;
        tick_if.starting        = 1'b0;
        tick_if.boost_key       = 1'b0;
        tick_if.steady_motion   = 1'b0;
        tick_if.speed_target    = '0;
        tick_if.measured_power  = '0;
        tick_if.power_remaining = '0;
        tick_if.cap_millivolts  = '0;
        ctl_if.ready            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset settings
        @(posedge i_clk);
        offer(mk_tick(1, 1, 1, -65536, 16383, 1023, 36300)); // starting before any active tick
        offer(mk_tick(0, 0, 0, 0, 0, 1023, 0));
        offer(mk_tick(0, 0, 1, 100, 16383, 1023, 1000));
        offer(mk_tick(0, 0, 0, -1, 4800, 500, 5000));         // zero divisor
        offer(mk_tick(0, 0, 1, -65536, 3000, 500, 5000));
        offer(mk_tick(0, 0, 0, 65535, 3000, 500, 5000));
        offer(mk_tick(0, 0, 0, 20000, 2000, 500, 5000));
        offer(mk_tick(0, 1, 1, 20000, 2000, 1023, 36300));    // boost under overvoltage
        offer(mk_tick(0, 1, 0, 300, 4000, 1023, 12000));      // cap at discharge threshold
        offer(mk_tick(0, 1, 0, 300, 4000, 1023, 12001));
        offer(mk_tick(0, 0, 0, 0, 4000, 49, 10000));          // low buffer protection
        offer(mk_tick(0, 0, 0, 0, 4000, 50, 10000));
        offer(mk_tick(0, 0, 1, 5, 4000, 600, 23499));
        offer(mk_tick(0, 0, 1, 5, 4000, 600, 23500));         // overvoltage protection
        offer(mk_tick(1, 0, 0, 0, 0, 0, 0));                  // starting repeats held set-point
        offer(mk_tick(0, 0, 0, 0, 4800, 700, 8000));          // zero power error
        wait_drained();

        // zero ratio numerator
        cfg_write(REG_SPEED_SCALE, 32'd0);
        @(posedge i_clk);
        offer(mk_tick(0, 0, 0, 3000, 0, 700, 8000));
        offer(mk_tick(0, 0, 1, -3000, 0, 700, 8000));
        offer(mk_tick(0, 0, 0, -1, 0, 700, 8000));
        wait_drained();

        // random phases over several register settings
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: s = '{RST_POWER_TARGET, RST_PROTECT_BUFFER, RST_DISCHARGE_MIN,
                         RST_OVERVOLT, RST_INTEG_LIMIT, RST_SPEED_SCALE};
                1: s = '{14'd16383, 10'd0, 16'd0, 16'd36300, 12'd4095, 16'd65535};
                2: s = '{14'd0, 10'd1023, 16'd36300, 16'd0, 12'd0, 16'd0};
                default: s = rand_settings();
            endcase
            load_settings(s);
            @(posedge i_clk);
            for (k = 0; k < PHASE_TICKS; k++) offer(rand_tick());
            if (ph == 4) hold_arm = ~hold_arm;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (want_ctl_q.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived", want_ctl_q.size()));
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
